>>> src/tsopt_pkg.sv
// ----------------------------------------------------------------------------
// TCP timestamp option parser package
// Shared item types, option codes and walk phases.
// ----------------------------------------------------------------------------
`default_nettype none

package tsopt_pkg;

  // Option kinds and lengths
  localparam logic [7:0] KindEol       = 8'd0;
  localparam logic [7:0] KindNop       = 8'd1;
  localparam logic [7:0] KindTimestamp = 8'd8;
  localparam logic [7:0] TsLength      = 8'd10;
  localparam logic [7:0] MinOptLength  = 8'd2;
  localparam logic [3:0] BaseHdrWords  = 4'd5;

  // Option space in bytes (at most 40) and body counter
  localparam int unsigned RemW  = 6;
  localparam int unsigned BodyW = 6;
  localparam logic [BodyW-1:0] TsBodyBytes = 6'd8;
  localparam logic [BodyW-1:0] EchoBytes   = 6'd4;

  // Walk phases, one-hot
  typedef enum logic [5:0] {
    PH_KIND  = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_SKIP  = 6'b000100,
    PH_TS    = 6'b001000,
    PH_STOP  = 6'b010000,
    PH_FOUND = 6'b100000
  } phase_e;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] header_words;
    logic       first_of_header;
    logic       last_of_header;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic        found;
    logic [31:0] ts_value;
    logic [31:0] ts_echo_reply;
  } out_t;

endpackage

`default_nettype wire

>>> src/tcp_timestamp_option_parser.sv
// ----------------------------------------------------------------------------
// TCP timestamp option parser
// Walks a TCP option area byte by byte and reports the timestamp option.
// ----------------------------------------------------------------------------
// One option byte enters per cycle while the input is not stalled. Each
// transaction is registered in the input register, from which the walk state
// advances; for the byte marked last the result register loads at the same
// edge, so a result is offered once its last byte leaves the input register.
// Only the byte marked last produces a result: found plus the timestamp
// value and echo reply, or zeros. The input stalls only while a last byte
// waits for the result register to be emptied.
`default_nettype none

module tcp_timestamp_option_parser (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire tsopt_pkg::in_t in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output tsopt_pkg::out_t     out_data_o
);
  import tsopt_pkg::*;

  // Input register
  logic in_valid_q;
  in_t  in_q;

  // Walk state
  logic [RemW-1:0]  remaining_q, remaining_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       kind_q, kind_d;
  logic [BodyW-1:0] body_q, body_d;
  logic [31:0]      value_q, value_d;
  logic [31:0]      echo_q, echo_d;
  logic             found_q, found_d;

  // Result register
  logic out_valid_q;
  out_t out_q;

  logic out_free;
  logic consume;
  logic in_take;

  // Start-of-header values
  logic [RemW-1:0]  rem_s;
  phase_e           phase_s;
  logic [7:0]       kind_s;
  logic [BodyW-1:0] body_s;
  logic [31:0]      value_s;
  logic [31:0]      echo_s;
  logic             found_s;
  logic [3:0]       extra_words;
  logic [7:0]       b;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && (!in_q.last_of_header || out_free);
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  // Capture an input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  assign b           = in_q.data_byte;
  assign extra_words = in_q.header_words - BaseHdrWords;

  // Restart the walk on the first byte of a header
  always_comb begin
    if (in_q.first_of_header) begin
      rem_s   = (in_q.header_words >= BaseHdrWords) ? {extra_words, 2'b00} : '0;
      phase_s = PH_KIND;
      kind_s  = '0;
      body_s  = '0;
      value_s = '0;
      echo_s  = '0;
      found_s = 1'b0;
    end else begin
      rem_s   = remaining_q;
      phase_s = phase_q;
      kind_s  = kind_q;
      body_s  = body_q;
      value_s = value_q;
      echo_s  = echo_q;
      found_s = found_q;
    end
  end

  // Advance the walk by one byte
  always_comb begin
    remaining_d = rem_s;
    phase_d     = phase_s;
    kind_d      = kind_s;
    body_d      = body_s;
    value_d     = value_s;
    echo_d      = echo_s;
    found_d     = found_s;
    unique case (phase_s)
      PH_KIND: begin
        if (rem_s == '0 || b == KindEol) begin
          phase_d = PH_STOP;
        end else if (b == KindNop) begin
          remaining_d = rem_s - RemW'(1);
        end else begin
          kind_d  = b;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < MinOptLength || b > {2'b00, rem_s}) begin
          phase_d = PH_STOP;
        end else if (kind_s == KindTimestamp && b == TsLength) begin
          body_d  = TsBodyBytes;
          phase_d = PH_TS;
        end else begin
          remaining_d = rem_s - b[RemW-1:0];
          body_d      = b[BodyW-1:0] - MinOptLength[BodyW-1:0];
          phase_d     = (b == MinOptLength) ? PH_KIND : PH_SKIP;
        end
      end
      PH_SKIP: begin
        body_d = body_s - BodyW'(1);
        if (body_s == BodyW'(1)) begin
          phase_d = PH_KIND;
        end
      end
      PH_TS: begin
        if (body_s > EchoBytes) begin
          value_d = {value_s[23:0], b};
        end else begin
          echo_d = {echo_s[23:0], b};
        end
        body_d = body_s - BodyW'(1);
        if (body_s == BodyW'(1)) begin
          found_d = 1'b1;
          phase_d = PH_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Update walk state; clear it after a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      phase_q     <= PH_KIND;
      kind_q      <= '0;
      body_q      <= '0;
      value_q     <= '0;
      echo_q      <= '0;
      found_q     <= 1'b0;
    end else if (consume) begin
      if (in_q.last_of_header) begin
        remaining_q <= '0;
        phase_q     <= PH_STOP;
        kind_q      <= '0;
        body_q      <= '0;
        value_q     <= '0;
        echo_q      <= '0;
        found_q     <= 1'b0;
      end else begin
        remaining_q <= remaining_d;
        phase_q     <= phase_d;
        kind_q      <= kind_d;
        body_q      <= body_d;
        value_q     <= value_d;
        echo_q      <= echo_d;
        found_q     <= found_d;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= consume && in_q.last_of_header;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_q.last_of_header) begin
      out_q.found         <= found_d;
      out_q.ts_value      <= found_d ? value_d : '0;
      out_q.ts_echo_reply <= found_d ? echo_d : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
